/* rtl/core/dpsf_pkg.sv */
// Shared constants, codes and helpers for the dual position sensor fusion block.
// Used by dpsf_div and dual_position_sensor_fusion_top; depends on nothing.
package dpsf_pkg;

	localparam int unsigned QUAL_FLOOR  = 90;
	localparam int unsigned QUAL_MAX    = 100;
	localparam int unsigned SYNC_QUAL   = 99;
	localparam int unsigned MS_PER_S    = 1000;
	localparam int unsigned HEADING_MAX = 35999;
	localparam int unsigned VEL_POS_MAX = 262143;
	localparam int unsigned VEL_NEG_MAX = 262144;

	// Shared divider widths: dividend covers |dx| * 1000 + dt / 2, divisor covers dt
	localparam int unsigned DIV_NUM_W = 32;
	localparam int unsigned DIV_DEN_W = 32;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		OP_X  = 3'd0,
		OP_Y  = 3'd1,
		OP_H  = 3'd2,
		OP_VX = 3'd3,
		OP_VY = 3'd4
	} op_t;

	// Weight in tenths of full quality: quality clamped to 100, minus 90, floored at 0
	function automatic logic [3:0] weight_of(input logic [6:0] q);
		logic [6:0] qs;
		logic [6:0] w;
		qs = (q > 7'(QUAL_MAX)) ? 7'(QUAL_MAX) : q;
		w  = (qs >= 7'(QUAL_FLOOR)) ? (qs - 7'(QUAL_FLOOR)) : 7'd0;
		return w[3:0];
	endfunction

endpackage

/* rtl/core/dpsf_div.sv */
// Restoring divider, one quotient bit per cycle, shared by every division of a request.
// Depends on dpsf_pkg for its default widths.
module dpsf_div #(
	parameter int unsigned NUM_W = dpsf_pkg::DIV_NUM_W,
	parameter int unsigned DEN_W = dpsf_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("divider done without a finished run");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with an empty bit count");

endmodule

/* rtl/core/dual_position_sensor_fusion_top.sv */
// Dual position sensor fusion: quality weighted average of two readings plus velocity.
// Depends on dpsf_pkg and dpsf_div.
//
// Usage:
//   Input channel in_valid / in_ready carries one request: both sensors' x, y,
//   heading and quality plus the left sensor's millisecond timestamp. Output
//   channel out_valid / out_ready carries the fused x, y, heading, velocity,
//   total weight, timestamp and heading sync flag.
//   A request whose qualities are both 90 or below is taken and dropped:
//   no result, and the stored position and time stay as they were.
//   Otherwise five divisions run one after another on a single bit-serial
//   divider (x, y, heading, x velocity, y velocity), each after its operand
//   preparation; when the timestamp equals the stored one both velocity
//   divisions are skipped. in_ready is high only while the sequencer is
//   idle, so one request is processed at a time.
//   The result sits in an output register: the next request is taken while
//   it waits, and a stalled receiver only holds the sequencer at its final
//   step until the register frees.
//   Reset clears the stored position and time to zero and empties the block.
module dual_position_sensor_fusion_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] left_y,
	input  logic        [15:0] left_heading,
	input  logic        [6:0]  left_quality,
	input  logic signed [15:0] right_x,
	input  logic signed [15:0] right_y,
	input  logic        [15:0] right_heading,
	input  logic        [6:0]  right_quality,
	input  logic        [31:0] sample_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] fused_x,
	output logic signed [15:0] fused_y,
	output logic        [15:0] fused_heading,
	output logic signed [18:0] vel_x,
	output logic signed [18:0] vel_y,
	output logic        [4:0]  total_weight,
	output logic        [31:0] fused_time,
	output logic               heading_sync
);

	localparam int unsigned NW = dpsf_pkg::DIV_NUM_W;
	localparam int unsigned DW = dpsf_pkg::DIV_DEN_W;

	dpsf_pkg::state_t state_q;
	dpsf_pkg::op_t    op_q;
	logic             out_valid_q;

	// State kept between requests
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic        [31:0] prev_time_q;

	// Captured request
	logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
	logic        [15:0] lh_q, rh_q;
	logic        [3:0]  wl_q, wr_q;
	logic        [4:0]  wt_q;
	logic        [31:0] t_q;
	logic        [31:0] dt_q;
	logic               sync_q;

	// Working results
	logic signed [15:0] fx_q, fy_q;
	logic        [15:0] fh_q;
	logic signed [18:0] vx_q, vy_q;
	logic        [27:0] mag_q;
	logic               neg_q;

	// Output register
	logic signed [15:0] fused_x_q, fused_y_q;
	logic        [15:0] fused_heading_q;
	logic signed [18:0] vel_x_q, vel_y_q;
	logic        [4:0]  total_weight_q;
	logic        [31:0] fused_time_q;
	logic               heading_sync_q;

	logic [3:0] wl_in, wr_in;
	logic [4:0] wt_in;
	logic       in_acc;
	logic       is_vel;
	logic       skip_vel;
	logic       fin_go;

	logic signed [20:0] pos_sum;
	logic        [20:0] head_sum;
	logic signed [16:0] vdiff;
	logic signed [27:0] num_s;
	logic        [27:0] num_mag;

	logic          div_start;
	logic [NW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [NW-1:0] div_quo;

	logic signed [15:0] xy_res;
	logic        [15:0] h_res;
	logic signed [18:0] v_res;

	always_comb begin
		wl_in  = dpsf_pkg::weight_of(left_quality);
		wr_in  = dpsf_pkg::weight_of(right_quality);
		wt_in  = {1'b0, wl_in} + {1'b0, wr_in};
		in_acc = in_valid && in_ready;
	end

	assign in_ready = (state_q == dpsf_pkg::S_IDLE);
	assign is_vel   = (op_q == dpsf_pkg::OP_VX) || (op_q == dpsf_pkg::OP_VY);
	assign skip_vel = is_vel && (dt_q == '0);
	assign fin_go   = (state_q == dpsf_pkg::S_FIN) && (!out_valid_q || out_ready);

	// Signed numerator of the current division
	always_comb begin
		case (op_q)
			dpsf_pkg::OP_X: begin
				pos_sum = lx_q * $signed({1'b0, wl_q}) + rx_q * $signed({1'b0, wr_q});
				vdiff   = '0;
			end
			dpsf_pkg::OP_Y: begin
				pos_sum = ly_q * $signed({1'b0, wl_q}) + ry_q * $signed({1'b0, wr_q});
				vdiff   = '0;
			end
			dpsf_pkg::OP_VX: begin
				pos_sum = '0;
				vdiff   = $signed({fx_q[15], fx_q}) - $signed({prev_x_q[15], prev_x_q});
			end
			dpsf_pkg::OP_VY: begin
				pos_sum = '0;
				vdiff   = $signed({fy_q[15], fy_q}) - $signed({prev_y_q[15], prev_y_q});
			end
			default: begin
				pos_sum = '0;
				vdiff   = '0;
			end
		endcase
		head_sum = {5'b0, lh_q} * {17'b0, wl_q} + {5'b0, rh_q} * {17'b0, wr_q};
		case (op_q)
			dpsf_pkg::OP_X, dpsf_pkg::OP_Y: num_s = 28'(pos_sum);
			dpsf_pkg::OP_H:                 num_s = $signed({7'b0, head_sum});
			dpsf_pkg::OP_VX, dpsf_pkg::OP_VY:
				num_s = $signed(28'(vdiff)) * $signed(28'(dpsf_pkg::MS_PER_S));
			default:                        num_s = '0;
		endcase
		num_mag = num_s[27] ? 28'(-num_s) : 28'(num_s);
	end

	// Round half away from zero: add half the divisor to the magnitude
	always_comb begin
		div_divisor  = is_vel ? dt_q : {27'b0, wt_q};
		div_dividend = {4'b0, mag_q} + {1'b0, div_divisor[DW-1:1]};
		div_start    = (state_q == dpsf_pkg::S_START);
	end

	dpsf_div #(
		.NUM_W (dpsf_pkg::DIV_NUM_W),
		.DEN_W (dpsf_pkg::DIV_DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Reapply sign and clamp
	always_comb begin
		xy_res = neg_q ? $signed(16'd0 - div_quo[15:0]) : $signed(div_quo[15:0]);
		h_res  = (div_quo > NW'(dpsf_pkg::HEADING_MAX)) ?
			16'(dpsf_pkg::HEADING_MAX) : div_quo[15:0];
		if (neg_q) begin
			v_res = (div_quo > NW'(dpsf_pkg::VEL_NEG_MAX)) ?
				$signed(19'd0 - 19'(dpsf_pkg::VEL_NEG_MAX)) :
				$signed(19'd0 - div_quo[18:0]);
		end else begin
			v_res = (div_quo > NW'(dpsf_pkg::VEL_POS_MAX)) ?
				$signed(19'(dpsf_pkg::VEL_POS_MAX)) : $signed(div_quo[18:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpsf_pkg::S_IDLE;
			op_q        <= dpsf_pkg::OP_X;
			out_valid_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				dpsf_pkg::S_IDLE: begin
					// drop a request with no usable quality
					if (in_acc && (wt_in != '0)) begin
						state_q <= dpsf_pkg::S_PREP;
						op_q    <= dpsf_pkg::OP_X;
					end
				end
				dpsf_pkg::S_PREP: begin
					if (skip_vel) begin
						if (op_q == dpsf_pkg::OP_VY) begin
							state_q <= dpsf_pkg::S_FIN;
						end else begin
							op_q <= dpsf_pkg::OP_VY;
						end
					end else begin
						state_q <= dpsf_pkg::S_START;
					end
				end
				dpsf_pkg::S_START: begin
					state_q <= dpsf_pkg::S_DIV;
				end
				dpsf_pkg::S_DIV: begin
					if (div_done) begin
						case (op_q)
							dpsf_pkg::OP_X:  op_q <= dpsf_pkg::OP_Y;
							dpsf_pkg::OP_Y:  op_q <= dpsf_pkg::OP_H;
							dpsf_pkg::OP_H:  op_q <= dpsf_pkg::OP_VX;
							dpsf_pkg::OP_VX: op_q <= dpsf_pkg::OP_VY;
							default:         op_q <= dpsf_pkg::OP_X;
						endcase
						state_q <= (op_q == dpsf_pkg::OP_VY) ?
							dpsf_pkg::S_FIN : dpsf_pkg::S_PREP;
					end
				end
				dpsf_pkg::S_FIN: begin
					// hold until the output register is free
					if (fin_go) begin
						out_valid_q <= 1'b1;
						prev_x_q    <= fx_q;
						prev_y_q    <= fy_q;
						prev_time_q <= t_q;
						state_q     <= dpsf_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= dpsf_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lx_q   <= left_x;
			ly_q   <= left_y;
			lh_q   <= left_heading;
			rx_q   <= right_x;
			ry_q   <= right_y;
			rh_q   <= right_heading;
			wl_q   <= wl_in;
			wr_q   <= wr_in;
			wt_q   <= wt_in;
			t_q    <= sample_time;
			dt_q   <= sample_time - prev_time_q;
			sync_q <= (left_quality >= 7'(dpsf_pkg::SYNC_QUAL)) &&
				(right_quality >= 7'(dpsf_pkg::SYNC_QUAL));
		end
		if (state_q == dpsf_pkg::S_PREP) begin
			mag_q <= num_mag;
			neg_q <= num_s[27];
			if (skip_vel) begin
				if (op_q == dpsf_pkg::OP_VX) begin
					vx_q <= '0;
				end else begin
					vy_q <= '0;
				end
			end
		end
		if ((state_q == dpsf_pkg::S_DIV) && div_done) begin
			case (op_q)
				dpsf_pkg::OP_X:  fx_q <= xy_res;
				dpsf_pkg::OP_Y:  fy_q <= xy_res;
				dpsf_pkg::OP_H:  fh_q <= h_res;
				dpsf_pkg::OP_VX: vx_q <= v_res;
				dpsf_pkg::OP_VY: vy_q <= v_res;
				default: ;
			endcase
		end
		if (fin_go) begin
			fused_x_q       <= fx_q;
			fused_y_q       <= fy_q;
			fused_heading_q <= fh_q;
			vel_x_q         <= vx_q;
			vel_y_q         <= vy_q;
			total_weight_q  <= wt_q;
			fused_time_q    <= t_q;
			heading_sync_q  <= sync_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign fused_x       = fused_x_q;
	assign fused_y       = fused_y_q;
	assign fused_heading = fused_heading_q;
	assign vel_x         = vel_x_q;
	assign vel_y         = vel_y_q;
	assign total_weight  = total_weight_q;
	assign fused_time    = fused_time_q;
	assign heading_sync  = heading_sync_q;

	a_drop_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (wt_in == '0)) |=> (state_q == dpsf_pkg::S_IDLE))
		else $error("request with zero weight was not dropped");

	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (out_valid_q && (state_q == dpsf_pkg::S_IDLE)))
		else $error("final step did not present a result");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fused_heading_q <= 16'(dpsf_pkg::HEADING_MAX)))
		else $error("fused heading out of range");

	a_weight_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (total_weight_q != '0))
		else $error("result presented with zero total weight");

endmodule

/* tb/dual_position_sensor_fusion_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dual_position_sensor_fusion_top.
// Holds its own model of the quality weighted fusion and velocity tracking,
// drives requests under varied pacing and checks every fused sample; needs only the RTL.
module dual_position_sensor_fusion_top_tb;

	localparam int QUALITY_FLOOR = 90;
	localparam int QUALITY_CEIL  = 100;
	localparam int SYNC_LEVEL    = 99;
	localparam int HEADING_LIMIT = 35999;
	localparam int MS_PER_SECOND = 1000;
	localparam int VEL_HI        = 262143;
	localparam int VEL_LO        = -262144;
	localparam int QUIET_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 250;
	localparam int PRINT_CAP     = 30;

	typedef struct packed {
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] lh;
		logic [6:0]  lq;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rh;
		logic [6:0]  rq;
		logic [31:0] t;
	} sensor_pair_t;

	typedef struct packed {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fh;
		logic [18:0] vx;
		logic [18:0] vy;
		logic [4:0]  wt;
		logic [31:0] t;
		logic        sync;
	} fusion_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] left_x = '0;
	logic signed [15:0] left_y = '0;
	logic        [15:0] left_heading = '0;
	logic        [6:0]  left_quality = '0;
	logic signed [15:0] right_x = '0;
	logic signed [15:0] right_y = '0;
	logic        [15:0] right_heading = '0;
	logic        [6:0]  right_quality = '0;
	logic        [31:0] sample_time = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] fused_x;
	logic signed [15:0] fused_y;
	logic        [15:0] fused_heading;
	logic signed [18:0] vel_x;
	logic signed [18:0] vel_y;
	logic        [4:0]  total_weight;
	logic        [31:0] fused_time;
	logic               heading_sync;

	dual_position_sensor_fusion_top dut (.*);

	sensor_pair_t pending_requests[$];
	fusion_t      expected_fusions[$];
	sensor_pair_t driven_request;
	sensor_pair_t next_request;
	fusion_t      predicted_fusion;
	fusion_t      want;

	// tracked position and time, as the block stores them
	longint      track_x = 0;
	longint      track_y = 0;
	logic [31:0] track_time = '0;

	// stimulus generator state
	logic [31:0] gen_time = '0;
	int          walk_x = 0;
	int          walk_y = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int requests_sent = 0;
	int dropped_requests = 0;
	int fusions_checked = 0;
	int sync_seen = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint quality_weight(input logic [6:0] q);
		longint qs;
		qs = (q > QUALITY_CEIL) ? QUALITY_CEIL : longint'(q);
		return (qs >= QUALITY_FLOOR) ? qs - QUALITY_FLOOR : 0;
	endfunction

	// nearest, ties away from zero; den is positive
	function automatic longint round_half_away(input longint num, input longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic logic [18:0] track_velocity(input longint now_pos, input longint last_pos,
			input logic [31:0] dt);
		longint v;
		if (dt == 0)
			return '0;
		v = round_half_away((now_pos - last_pos) * MS_PER_SECOND, longint'({32'd0, dt}));
		if (v > VEL_HI)
			v = VEL_HI;
		if (v < VEL_LO)
			v = VEL_LO;
		return v[18:0];
	endfunction

	// Fuse one request against the tracked state; returns 0 when no sample results.
	function automatic bit fuse_request(input sensor_pair_t r, output fusion_t f);
		longint wl, wr, wt, fx, fy, fh;
		logic [31:0] dt;
		f = '0;
		wl = quality_weight(r.lq);
		wr = quality_weight(r.rq);
		wt = wl + wr;
		if (wt == 0)
			return 1'b0;
		fx = round_half_away(longint'($signed(r.lx)) * wl + longint'($signed(r.rx)) * wr, wt);
		fy = round_half_away(longint'($signed(r.ly)) * wl + longint'($signed(r.ry)) * wr, wt);
		fh = round_half_away(longint'(r.lh) * wl + longint'(r.rh) * wr, wt);
		if (fh > HEADING_LIMIT)
			fh = HEADING_LIMIT;
		dt = r.t - track_time;
		f.fx = fx[15:0];
		f.fy = fy[15:0];
		f.fh = fh[15:0];
		f.vx = track_velocity(fx, track_x, dt);
		f.vy = track_velocity(fy, track_y, dt);
		f.wt = wt[4:0];
		f.t = r.t;
		f.sync = (r.lq >= SYNC_LEVEL) && (r.rq >= SYNC_LEVEL);
		track_x = fx;
		track_y = fy;
		track_time = r.t;
		return 1'b1;
	endfunction

	task automatic report_failure(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_val);
		if (got !== exp_val)
			report_failure($sformatf("%s got %0h, expected %0h", name, got, exp_val));
	endtask

	task automatic add_request(input int lx, input int ly, input int lh, input int lq,
			input int rx, input int ry, input int rh, input int rq, input logic [31:0] t);
		sensor_pair_t r;
		r.lx = 16'(lx);
		r.ly = 16'(ly);
		r.lh = 16'(lh);
		r.lq = 7'(lq);
		r.rx = 16'(rx);
		r.ry = 16'(ry);
		r.rh = 16'(rh);
		r.rq = 7'(rq);
		r.t = t;
		pending_requests.push_back(r);
	endtask

	task automatic load_directed();
		// full scale positions over one millisecond: both velocities saturate
		add_request(32767, -32768, 0, 100, 32767, -32768, 0, 100, 32'd1);
		add_request(-32768, 32767, 35999, 100, -32768, 32767, 35999, 100, 32'd2);
		// both weights zero: drop, state kept
		add_request(1000, 1000, 100, 0, 1000, 1000, 100, 0, 32'd3);
		add_request(-500, 500, 200, 89, 700, -700, 300, 90, 32'd4);
		// clamped qualities, heading mean above range, no time elapsed
		add_request(0, 0, 65535, 127, 0, 0, 65535, 127, 32'd2);
		// one sensor carries all the weight
		add_request(100, -200, 1234, 95, -5000, 5000, 30000, 50, 32'd18);
		add_request(-3000, 4000, 9000, 80, 250, -350, 27000, 91, 32'd34);
		// halfway ties round away from zero
		add_request(0, 0, 0, 91, 1, -1, 1, 91, 32'd50);
		// sync flag at the threshold
		add_request(10, 20, 100, 99, 12, 22, 110, 98, 32'd66);
		add_request(14, 24, 120, 98, 16, 26, 130, 99, 32'd82);
		add_request(18, 28, 140, 99, 20, 30, 150, 99, 32'd98);
		add_request(22, 32, 160, 100, 24, 34, 170, 101, 32'd114);
		// timestamp wrap
		add_request(30, 40, 200, 95, 32, 42, 210, 96, 32'hFFFF_FFF0);
		add_request(300, -400, 220, 95, 320, -420, 230, 96, 32'h0000_0010);
		add_request(-300, 400, 240, 95, -320, 420, 250, 96, 32'hFFFF_FFFF);
		add_request(-310, 410, 260, 95, -330, 430, 270, 96, 32'hFFFF_FFFF);
		// uneven weights
		add_request(1, -1, 10, 91, 2, -2, 11, 93, 32'h0000_0100);
		add_request(-7, 7, 35999, 127, 9, -9, 0, 0, 32'h0000_0110);
		// linear heading mean across north
		add_request(0, 0, 35999, 95, 0, 0, 0, 95, 32'h0000_0120);
		add_request(5, 5, 65535, 91, 5, 5, 0, 100, 32'h0000_0130);
		gen_time = 32'h0000_0130;
	endtask

	function automatic int pick_quality();
		case ($urandom_range(19))
			0: return int'($urandom_range(0, 89));
			1: return int'($urandom_range(101, 127));
			2, 3: return int'($urandom_range(99, 100));
			default: return int'($urandom_range(90, 100));
		endcase
	endfunction

	function automatic int pick_heading();
		if ($urandom_range(9) == 0)
			return int'($urandom_range(0, 65535));
		return int'($urandom_range(0, HEADING_LIMIT));
	endfunction

	task automatic add_random_requests(input int target);
		int made;
		int lq, rq;
		made = 0;
		while (made < target) begin
			if ($urandom_range(11) == 0) begin
				lq = int'($urandom_range(0, 89));
				rq = int'($urandom_range(0, 89));
			end else begin
				lq = pick_quality();
				rq = pick_quality();
			end
			case ($urandom_range(19))
				0: ;
				1: gen_time = $urandom;
				2, 3: gen_time += $urandom_range(1, 4);
				default: gen_time += $urandom_range(10, 40);
			endcase
			if ($urandom_range(3) == 0) begin
				add_request(int'($urandom), int'($urandom), pick_heading(), lq,
					int'($urandom), int'($urandom), pick_heading(), rq, gen_time);
			end else begin
				// track a moving robot: both sensors close to one another
				walk_x += int'($urandom_range(0, 400)) - 200;
				walk_y += int'($urandom_range(0, 400)) - 200;
				add_request(walk_x + int'($urandom_range(0, 40)) - 20,
					walk_y + int'($urandom_range(0, 40)) - 20, pick_heading(), lq,
					walk_x + int'($urandom_range(0, 40)) - 20,
					walk_y + int'($urandom_range(0, 40)) - 20, pick_heading(), rq, gen_time);
			end
			if (quality_weight(7'(lq)) + quality_weight(7'(rq)) != 0)
				made++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				requests_sent++;
				if (fuse_request(driven_request, predicted_fusion))
					expected_fusions.push_back(predicted_fusion);
				else
					dropped_requests++;
			end
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_request = pending_requests.pop_front();
				driven_request = next_request;
				in_valid <= 1'b1;
				left_x <= next_request.lx;
				left_y <= next_request.ly;
				left_heading <= next_request.lh;
				left_quality <= next_request.lq;
				right_x <= next_request.rx;
				right_y <= next_request.ry;
				right_heading <= next_request.rh;
				right_quality <= next_request.rq;
				sample_time <= next_request.t;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (expected_fusions.size() == 0) begin
					report_failure("fused sample with no request waiting");
				end else begin
					want = expected_fusions.pop_front();
					check_field("fused_x", 32'($unsigned(fused_x)), 32'(want.fx));
					check_field("fused_y", 32'($unsigned(fused_y)), 32'(want.fy));
					check_field("fused_heading", 32'(fused_heading), 32'(want.fh));
					check_field("vel_x", 32'($unsigned(vel_x)), 32'(want.vx));
					check_field("vel_y", 32'($unsigned(vel_y)), 32'(want.vy));
					check_field("total_weight", 32'(total_weight), 32'(want.wt));
					check_field("fused_time", fused_time, want.t);
					check_field("heading_sync", 32'(heading_sync), 32'(want.sync));
					if (want.sync)
						sync_seen++;
					fusions_checked++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			if (phase == 0)
				load_directed();
			add_random_requests((phase == 0) ? 85 : 105);
			// hold new requests back until every fused sample has come out
			while (pending_requests.size() != 0 || in_valid || expected_fusions.size() != 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d requests (%0d dropped for zero weight), checked %0d fused samples,",
			requests_sent, dropped_requests, fusions_checked);
		$display("%0d with heading sync, across free running, sender, receiver and mixed stalls",
			sync_seen);
		if (error_count == 0 && expected_fusions.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/dpsf_pkg.sv
rtl/core/dpsf_div.sv
rtl/core/dual_position_sensor_fusion_top.sv
tb/dual_position_sensor_fusion_top_tb.sv
